/* design/smkt_pkg.sv */
package smkt_pkg;

    // Operation codes carried in tuser
    localparam logic [2:0] OP_KEY        = 3'd0;
    localparam logic [2:0] OP_AUTO_CAPS  = 3'd1;
    localparam logic [2:0] OP_IND_CLICK  = 3'd2;
    localparam logic [2:0] OP_CONTENT    = 3'd3;
    localparam logic [2:0] OP_SOFT_RESET = 3'd4;

    // Key classes
    localparam logic [2:0] KC_SHIFT = 3'd0;
    localparam logic [2:0] KC_FN    = 3'd1;
    localparam logic [2:0] KC_SYM   = 3'd2;
    localparam logic [2:0] KC_MOD   = 3'd3;

    // Modifier modes
    localparam logic [1:0] MODE_CLEAR   = 2'd0;
    localparam logic [1:0] MODE_LATCHED = 2'd1;
    localparam logic [1:0] MODE_LOCKED  = 2'd2;

    // Content kinds
    localparam logic [1:0] CT_FREE   = 2'd0;
    localparam logic [1:0] CT_NUMBER = 2'd1;
    localparam logic [1:0] CT_PHONE  = 2'd2;

    // Held key bits
    localparam int HELD_SYM_BIT = 2;

    typedef struct packed {
        logic [1:0] shift_state;
        logic       shift_between;
        logic [1:0] fn_state;
        logic       fn_between;
        logic [2:0] held_keys;
        logic       sym_char_seen;
        logic       auto_caps_on;
        logic       filter_next;
        logic [1:0] content_kind;
    } state_t;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] key_class;
        logic       key_pressed;
        logic       force_processing;
        logic       caps_value;
        logic [1:0] content_type_value;
    } item_t;

    typedef struct packed {
        logic       eaten;
        logic [1:0] shift_mode;
        logic [1:0] fn_mode;
        logic       symbol_click;
        logic       accent_compose;
        logic       accent_commit;
        logic       shift_changed;
        logic       symbol_view_ok;
    } result_t;

endpackage

/* design/smkt_eval.sv */
module smkt_eval
    import smkt_pkg::*;
(
    input  state_t  state_cur,
    input  item_t   item,
    output state_t  state_next,
    output result_t result
);

    typedef struct packed {
        state_t st;
        logic   pulse;
    } work_t;

    // Move one modifier to a target mode; number content only lets Fn lock
    function automatic work_t set_mod(work_t w_in, logic which, logic [1:0] target);
        work_t      w;
        logic [1:0] cur;
        w   = w_in;
        cur = which ? w.st.fn_state : w.st.shift_state;
        if (!(w.st.content_kind == CT_NUMBER && !(which && target == MODE_LOCKED))
            && target != cur)
        begin
            if (which)
            begin
                w.st.fn_state = target;
                if (target == MODE_CLEAR)
                    w.st.fn_between = 1'b0;
            end
            else
            begin
                w.st.shift_state = target;
                if (target == MODE_CLEAR)
                    w.st.shift_between = 1'b0;
                w.pulse = 1'b1;
            end
        end
        return w;
    endfunction

    function automatic work_t mod_press(work_t w_in, logic which);
        work_t w;
        w = w_in;
        if ((which ? w.st.shift_state : w.st.fn_state) != MODE_CLEAR)
            w = set_mod(w, !which, MODE_CLEAR);
        if ((which ? w.st.fn_state : w.st.shift_state) == MODE_CLEAR)
            w = set_mod(w, which, MODE_LATCHED);
        return w;
    endfunction

    // Release cycles latched, latched again, locked, clear; a shift latched by auto caps clears on release
    function automatic work_t mod_release(work_t w_in, logic which);
        work_t      w;
        logic [1:0] cur;
        logic [1:0] target;
        w      = w_in;
        cur    = which ? w.st.fn_state : w.st.shift_state;
        target = MODE_CLEAR;
        if (cur != MODE_CLEAR)
        begin
            if (cur == MODE_LATCHED)
            begin
                if (!which && w.st.auto_caps_on)
                    w.st.auto_caps_on = 1'b0;
                else if (which ? w.st.fn_between : w.st.shift_between)
                    target = MODE_LOCKED;
                else
                begin
                    if (which)
                        w.st.fn_between = 1'b1;
                    else
                        w.st.shift_between = 1'b1;
                    target = MODE_LATCHED;
                end
            end
            w = set_mod(w, which, target);
            w.st.filter_next = 1'b1;
        end
        return w;
    endfunction

    work_t w_cur;
    logic  filter_this;
    logic  click_sel;
    logic  eaten;
    logic  sym_click;
    logic  compose;
    logic  commit;

    always_comb
    begin
        w_cur.st    = state_cur;
        w_cur.pulse = 1'b0;
        filter_this = 1'b0;
        click_sel   = 1'b0;
        eaten       = 1'b0;
        sym_click   = 1'b0;
        compose     = 1'b0;
        commit      = 1'b0;
        unique case (item.op)
            OP_KEY:
            begin
                filter_this          = w_cur.st.filter_next;
                w_cur.st.filter_next = 1'b0;
                if (item.key_class <= KC_SYM)
                begin
                    if (item.key_class != KC_SYM)
                    begin
                        if (item.key_pressed)
                            w_cur = mod_press(w_cur, item.key_class[0]);
                        else
                            w_cur = mod_release(w_cur, item.key_class[0]);
                    end
                    else if (!item.key_pressed)
                    begin
                        if (!w_cur.st.sym_char_seen)
                        begin
                            sym_click = 1'b1;
                            if (w_cur.st.shift_state != MODE_CLEAR
                                || w_cur.st.fn_state != MODE_CLEAR)
                                w_cur.st.filter_next = 1'b1;
                        end
                        else
                            commit = 1'b1;
                    end
                    w_cur.st.held_keys[item.key_class[1:0]] = item.key_pressed;
                    if (item.key_class == KC_SYM)
                        w_cur.st.sym_char_seen = 1'b0;
                end
                else if (filter_this || item.force_processing || w_cur.st.held_keys != 3'd0)
                begin
                    if (item.key_class != KC_MOD && item.key_pressed)
                    begin
                        if (w_cur.st.shift_state == MODE_LATCHED)
                            w_cur = set_mod(w_cur, 1'b0, MODE_CLEAR);
                        if (w_cur.st.fn_state == MODE_LATCHED)
                            w_cur = set_mod(w_cur, 1'b1, MODE_CLEAR);
                        if (w_cur.st.held_keys[HELD_SYM_BIT])
                        begin
                            compose                = 1'b1;
                            w_cur.st.sym_char_seen = 1'b1;
                        end
                    end
                    eaten = w_cur.st.held_keys[HELD_SYM_BIT];
                end
            end
            OP_AUTO_CAPS:
            begin
                if (w_cur.st.auto_caps_on != item.caps_value
                    && (w_cur.st.shift_state == MODE_CLEAR || w_cur.st.auto_caps_on))
                begin
                    w_cur = set_mod(w_cur, 1'b0, item.caps_value ? MODE_LATCHED : MODE_CLEAR);
                    w_cur.st.auto_caps_on = item.caps_value;
                end
            end
            OP_IND_CLICK:
            begin
                click_sel = (w_cur.st.shift_state == MODE_CLEAR)
                            && (w_cur.st.fn_state != MODE_CLEAR);
                w_cur = mod_press(w_cur, click_sel);
                w_cur = mod_release(w_cur, click_sel);
            end
            OP_CONTENT:
            begin
                w_cur.st.content_kind = item.content_type_value;
                if (item.content_type_value == CT_NUMBER || item.content_type_value == CT_PHONE)
                    w_cur = set_mod(w_cur, 1'b1, MODE_LOCKED);
            end
            OP_SOFT_RESET:
            begin
                w_cur.pulse              = (w_cur.st.shift_state != MODE_CLEAR);
                w_cur.st.shift_state     = MODE_CLEAR;
                w_cur.st.shift_between   = 1'b0;
                w_cur.st.fn_state        = MODE_CLEAR;
                w_cur.st.fn_between      = 1'b0;
                w_cur.st.held_keys       = 3'd0;
                w_cur.st.sym_char_seen   = 1'b0;
                w_cur.st.auto_caps_on    = 1'b0;
                w_cur.st.filter_next     = 1'b0;
            end
            default:
            begin
                w_cur.st = state_cur;
            end
        endcase
    end

    assign state_next              = w_cur.st;
    assign result.eaten            = eaten;
    assign result.shift_mode       = w_cur.st.shift_state;
    assign result.fn_mode          = w_cur.st.fn_state;
    assign result.symbol_click     = sym_click;
    assign result.accent_compose   = compose;
    assign result.accent_commit    = commit;
    assign result.shift_changed    = w_cur.pulse;
    assign result.symbol_view_ok   = !(w_cur.st.content_kind == CT_NUMBER
                                        || w_cur.st.content_kind == CT_PHONE);

endmodule

/* design/sticky_modifier_key_tracker_core.sv */
// Sticky Shift / Fn modifier tracker with Sym key handling.
//
// Input stream (s_*): one event per transfer. s_tuser holds the operation
// (key event, auto caps, indicator click, content type, soft reset) and
// s_tdata the event's arguments. Output stream (m_*): exactly one result per
// event, in order: swallow flag, both modifier modes, the Sym and shift pulses
// and whether the symbol view is allowed.
//
// An event is first taken into the input register; its result is loaded
// into the result register and offered on m_tvalid. Throughput: one event
// per cycle while m_tready is not held low; the event logic is a single
// pass over the tracker state between the input register and the result
// register, and the state updates in the same cycle the result is loaded.
//
// Reset (rst_n low, asynchronous) clears both modifiers, held keys, flags,
// auto caps and the content kind to free text, and empties both registers.
// When the receiver stalls, the pending result holds on m_tdata and the
// input register still takes one more event; s_tready drops once both are full.
module sticky_modifier_key_tracker_core
    import smkt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] key_class, [3] key_pressed, [4] force_processing,
    // [5] caps_value, [7:6] content_type_value
    input  logic [7:0]  s_tdata,
    // [2:0] op
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] eaten, [2:1] shift_mode, [4:3] fn_mode, [5] symbol_click,
    // [6] accent_compose, [7] accent_commit, [8] shift_changed,
    // [9] symbol_view_ok, [15:10] zero
    output logic [15:0] m_tdata
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_next;
    logic    advance;

    // Evaluate the held event when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    smkt_eval u_eval
    (
        .state_cur  (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Control state and tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: capture on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.op                 <= s_tuser;
            in_item_reg.key_class          <= s_tdata[2:0];
            in_item_reg.key_pressed        <= s_tdata[3];
            in_item_reg.force_processing   <= s_tdata[4];
            in_item_reg.caps_value         <= s_tdata[5];
            in_item_reg.content_type_value <= s_tdata[7:6];
        end
        if (advance)
            out_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0,
                       out_reg.symbol_view_ok,
                       out_reg.shift_changed,
                       out_reg.accent_commit,
                       out_reg.accent_compose,
                       out_reg.symbol_click,
                       out_reg.fn_mode,
                       out_reg.shift_mode,
                       out_reg.eaten};

`ifndef SYNTHESIS
    // Tracker state moves only when an event is evaluated
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("tracker state changed without an event");

    // A held event is never dropped while waiting for the result register
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("pending event lost");

    // Every evaluated event produces a result
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("evaluated event gave no result");

    // Soft reset leaves both modifiers clear and no keys held
    a_soft_reset: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.op == OP_SOFT_RESET |=>
            state_reg.shift_state == MODE_CLEAR && state_reg.fn_state == MODE_CLEAR
            && state_reg.held_keys == 3'd0)
        else $error("soft reset left modifier state behind");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import smkt_pkg::*;

    // Key classes and codes the package leaves unnamed
    localparam logic [2:0] KC_CHAR      = 3'd4;   // 4 is a character, 5..7 any other key
    localparam logic [2:0] KC_OTHER_TOP = 3'd7;   // highest "any other key" class
    localparam logic [2:0] OP_SPARE_TOP = 3'd7;   // ops 5..7 do nothing
    localparam logic [1:0] CT_SPARE     = 2'd3;   // behaves as free text
    localparam int SHIFT_IDX = 0;
    localparam int FN_IDX    = 1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [2:0] key_class, [3] key_pressed, [4] force_processing,
    // [5] caps_value, [7:6] content_type_value
    logic [7:0]  s_tdata = 8'd0;
    // [2:0] op
    logic [2:0]  s_tuser = 3'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [0] eaten, [2:1] shift_mode, [4:3] fn_mode, [5] symbol_click,
    // [6] accent_compose, [7] accent_commit, [8] shift_changed,
    // [9] symbol_view_ok, [15:10] zero
    logic [15:0] m_tdata;

    sticky_modifier_key_tracker_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Tracker mirror: our own copy of the modifier state
    // ------------------------------------------------------------------
    logic [1:0] mod_mode [2];     // per modifier: clear, latched or locked
    bit         mod_again [2];    // released once while latched, next release locks
    bit   [2:0] keys_down;        // bit 0 shift, bit 1 fn, bit 2 sym
    bit         char_in_sym;      // a character was typed while sym was held
    bit         caps_latch;       // shift latched by auto capitalisation
    bit         skip_next;        // next unmatched key is handled as if a key were held
    logic [1:0] content_sel;
    bit         shift_pulse;

    // Events waiting to be offered, with an optional hand-typed expectation
    item_t      event_feed [$];
    bit         feed_typed [$];
    result_t    feed_want [$];
    // Expectations for transfers taken but not yet answered
    result_t    owed_results [$];
    int         mismatch_count = 0;

    // Move one modifier; number content only lets fn go to locked
    function automatic void move_mod(int which, logic [1:0] target);
        if (content_sel == CT_NUMBER && !(which == FN_IDX && target == MODE_LOCKED))
            return;
        if (target == mod_mode[which])
            return;
        if (target == MODE_CLEAR)
            mod_again[which] = 1'b0;
        mod_mode[which] = target;
        if (which == SHIFT_IDX)
            shift_pulse = 1'b1;
    endfunction

    function automatic void press_mod(int which);
        int other;
        other = 1 - which;
        if (mod_mode[other] != MODE_CLEAR)
            move_mod(other, MODE_CLEAR);
        if (mod_mode[which] == MODE_CLEAR)
            move_mod(which, MODE_LATCHED);
    endfunction

    // Release walks latched -> latched again -> locked -> clear;
    // a shift latched by auto caps clears on its first release
    function automatic void release_mod(int which);
        logic [1:0] next_mode;
        next_mode = MODE_CLEAR;
        if (mod_mode[which] == MODE_CLEAR)
            return;
        if (mod_mode[which] == MODE_LATCHED) begin
            if (which == SHIFT_IDX && caps_latch)
                caps_latch = 1'b0;
            else if (mod_again[which])
                next_mode = MODE_LOCKED;
            else begin
                mod_again[which] = 1'b1;
                next_mode = MODE_LATCHED;
            end
        end
        move_mod(which, next_mode);
        skip_next = 1'b1;
    endfunction

    function automatic void clear_tracker(bit keep_content);
        mod_mode[SHIFT_IDX]  = MODE_CLEAR;
        mod_mode[FN_IDX]     = MODE_CLEAR;
        mod_again[SHIFT_IDX] = 1'b0;
        mod_again[FN_IDX]    = 1'b0;
        keys_down   = 3'b000;
        char_in_sym = 1'b0;
        caps_latch  = 1'b0;
        skip_next   = 1'b0;
        if (!keep_content)
            content_sel = CT_FREE;
    endfunction

    // Advance the mirror by one event and return the result it owes
    function automatic result_t track_event(item_t ev);
        result_t    r;
        bit         skip_this;
        logic [2:0] held_bit;
        int         which;
        r = '0;
        shift_pulse = 1'b0;
        case (ev.op)
            OP_KEY:
            begin
                skip_this = skip_next;
                skip_next = 1'b0;
                if (ev.key_class <= KC_SYM) begin
                    held_bit = 3'b001 << ev.key_class;
                    if (ev.key_class != KC_SYM) begin
                        which = (ev.key_class == KC_FN) ? FN_IDX : SHIFT_IDX;
                        if (ev.key_pressed)
                            press_mod(which);
                        else
                            release_mod(which);
                    end
                    else if (!ev.key_pressed) begin
                        if (!char_in_sym) begin
                            r.symbol_click = 1'b1;
                            if (mod_mode[SHIFT_IDX] != MODE_CLEAR
                                || mod_mode[FN_IDX] != MODE_CLEAR)
                                skip_next = 1'b1;
                        end
                        else
                            r.accent_commit = 1'b1;
                    end
                    if (ev.key_pressed)
                        keys_down = keys_down | held_bit;
                    else
                        keys_down = keys_down & ~held_bit;
                    if (ev.key_class == KC_SYM)
                        char_in_sym = 1'b0;
                end
                else if (skip_this || ev.force_processing || keys_down != 3'b000) begin
                    if (ev.key_class != KC_MOD && ev.key_pressed) begin
                        if (mod_mode[SHIFT_IDX] == MODE_LATCHED)
                            move_mod(SHIFT_IDX, MODE_CLEAR);
                        if (mod_mode[FN_IDX] == MODE_LATCHED)
                            move_mod(FN_IDX, MODE_CLEAR);
                        if (keys_down[HELD_SYM_BIT]) begin
                            r.accent_compose = 1'b1;
                            char_in_sym = 1'b1;
                        end
                    end
                    if (keys_down[HELD_SYM_BIT])
                        r.eaten = 1'b1;
                end
            end
            OP_AUTO_CAPS:
            begin
                if (caps_latch != ev.caps_value
                    && (mod_mode[SHIFT_IDX] == MODE_CLEAR || caps_latch)) begin
                    move_mod(SHIFT_IDX, ev.caps_value ? MODE_LATCHED : MODE_CLEAR);
                    caps_latch = ev.caps_value;
                end
            end
            OP_IND_CLICK:
            begin
                which = (mod_mode[SHIFT_IDX] == MODE_CLEAR
                         && mod_mode[FN_IDX] != MODE_CLEAR) ? FN_IDX : SHIFT_IDX;
                press_mod(which);
                release_mod(which);
            end
            OP_CONTENT:
            begin
                content_sel = ev.content_type_value;
                if (ev.content_type_value == CT_NUMBER || ev.content_type_value == CT_PHONE)
                    move_mod(FN_IDX, MODE_LOCKED);
            end
            OP_SOFT_RESET:
            begin
                shift_pulse = (mod_mode[SHIFT_IDX] != MODE_CLEAR);
                clear_tracker(1'b1);
            end
            default:
            begin
            end
        endcase
        r.shift_mode     = mod_mode[SHIFT_IDX];
        r.fn_mode        = mod_mode[FN_IDX];
        r.shift_changed  = shift_pulse;
        r.symbol_view_ok = !(content_sel == CT_NUMBER || content_sel == CT_PHONE);
        return r;
    endfunction

    function automatic item_t pack_event(logic [2:0] op, logic [2:0] kc, logic pressed,
                                         logic force_p, logic caps, logic [1:0] ct);
        item_t ev;
        ev.op                 = op;
        ev.key_class          = kc;
        ev.key_pressed        = pressed;
        ev.force_processing   = force_p;
        ev.caps_value         = caps;
        ev.content_type_value = ct;
        return ev;
    endfunction

    task automatic enqueue(item_t ev, bit typed, result_t want);
        event_feed.push_back(ev);
        feed_typed.push_back(typed);
        feed_want.push_back(want);
    endtask

    // Key event with force_processing set now and then and the fields that do not steer it left random
    task automatic add_key(logic [2:0] kc, logic pressed);
        enqueue(pack_event(OP_KEY, kc, pressed, $urandom_range(0, 5) == 0,
                           1'($urandom_range(0, 1)), 2'($urandom_range(0, 3))), 1'b0, '0);
    endtask

    // Append one realistic gesture, or now and then pure noise
    task automatic add_gesture();
        int         pick;
        int         n_chars;
        logic [2:0] mod_kc;
        pick = $urandom_range(0, 99);
        mod_kc = $urandom_range(0, 1) ? KC_FN : KC_SHIFT;
        if (pick < 25) begin
            // modifier tap, sometimes with a character typed under it
            repeat ($urandom_range(1, 3)) begin
                add_key(mod_kc, 1'b1);
                if ($urandom_range(0, 2) == 0) begin
                    add_key(KC_CHAR, 1'b1);
                    add_key(KC_CHAR, 1'b0);
                end
                add_key(mod_kc, 1'b0);
            end
        end
        else if (pick < 45) begin
            // sym held over zero or more keys
            add_key(KC_SYM, 1'b1);
            n_chars = $urandom_range(0, 3);
            repeat (n_chars) begin
                add_key(KC_CHAR + 3'($urandom_range(0, 3)), 1'b1);
                add_key(KC_CHAR, 1'b0);
            end
            if ($urandom_range(0, 3) == 0)
                add_key(mod_kc, 1'b1);
            add_key(KC_SYM, 1'b0);
        end
        else if (pick < 57) begin
            add_key(KC_CHAR + 3'($urandom_range(0, 3)), 1'b1);
            add_key(KC_CHAR + 3'($urandom_range(0, 3)), 1'b0);
        end
        else if (pick < 64)
            enqueue(pack_event(OP_AUTO_CAPS, 3'($urandom_range(0, 7)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), 2'($urandom_range(0, 3))),
                    1'b0, '0);
        else if (pick < 72)
            enqueue(pack_event(OP_IND_CLICK, 3'($urandom_range(0, 7)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), 2'($urandom_range(0, 3))),
                    1'b0, '0);
        else if (pick < 78)
            // keep free text most of the time so the modifiers stay live
            enqueue(pack_event(OP_CONTENT, 3'($urandom_range(0, 7)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)),
                               $urandom_range(0, 1) ? CT_FREE : 2'($urandom_range(0, 3))),
                    1'b0, '0);
        else if (pick < 81)
            enqueue(pack_event(OP_SOFT_RESET, 3'($urandom_range(0, 7)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), 2'($urandom_range(0, 3))),
                    1'b0, '0);
        else
            enqueue(pack_event(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), 2'($urandom_range(0, 3))),
                    1'b0, '0);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: stall on a pattern chosen by bits 8:7 of a free-running count of cycles
    // ------------------------------------------------------------------
    logic [15:0] rx_tick = 16'd0;

    always @(posedge clk) begin
        rx_tick <= rx_tick + 16'd1;
        case (rx_tick[8:7])
            2'd0: m_tready <= 1'b1;                        // no stalls at all
            2'd1: m_tready <= 1'($urandom_range(0, 1));
            2'd2: m_tready <= ($urandom_range(0, 3) == 0);  // mostly stalled
            default: m_tready <= (rx_tick[2:0] != 3'd0);   // stall whenever rx_tick[2:0] is zero
        endcase
    end

    // Compare every result transfer with the oldest expectation
    result_t arrived_want;

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (owed_results.size() == 0) begin
                $error("result 0x%h arrived with nothing expected", m_tdata);
                mismatch_count++;
            end
            else begin
                arrived_want = owed_results.pop_front();
                check_field("eaten", int'(arrived_want.eaten), int'(m_tdata[0]));
                check_field("shift_mode", int'(arrived_want.shift_mode), int'(m_tdata[2:1]));
                check_field("fn_mode", int'(arrived_want.fn_mode), int'(m_tdata[4:3]));
                check_field("symbol_click", int'(arrived_want.symbol_click),
                            int'(m_tdata[5]));
                check_field("accent_compose", int'(arrived_want.accent_compose),
                            int'(m_tdata[6]));
                check_field("accent_commit", int'(arrived_want.accent_commit),
                            int'(m_tdata[7]));
                check_field("shift_changed", int'(arrived_want.shift_changed),
                            int'(m_tdata[8]));
                check_field("symbol_view_ok", int'(arrived_want.symbol_view_ok),
                            int'(m_tdata[9]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Event side: directed table, then random gestures, sent in bursts
    // ------------------------------------------------------------------
    initial begin
        result_t want_first_latch;
        result_t want_quiet_phone;
        result_t took;
        item_t   ev;
        bit      typed;
        int      n_directed;
        int      sent;
        int      burst_left;
        int      gap;

        clear_tracker(1'b0);

        // Shift pressed straight after reset: shift latches, nothing else moves
        want_first_latch = '0;
        want_first_latch.shift_mode     = MODE_LATCHED;
        want_first_latch.fn_mode        = MODE_CLEAR;
        want_first_latch.shift_changed  = 1'b1;
        want_first_latch.symbol_view_ok = 1'b1;
        // Spare op after a soft reset in phone content: all quiet, no symbol view
        want_quiet_phone = '0;
        want_quiet_phone.shift_mode = MODE_CLEAR;
        want_quiet_phone.fn_mode    = MODE_CLEAR;

        //      op             key class     prs   frc   caps  content
        enqueue(pack_event(OP_KEY,        KC_SHIFT,     1'b1, 1'b0, 1'b0, CT_FREE),
                1'b1, want_first_latch);
        enqueue(pack_event(OP_KEY,        KC_SHIFT,     1'b0, 1'b0, 1'b0, CT_FREE), 1'b0, '0);
        enqueue(pack_event(OP_KEY,        KC_SHIFT,     1'b1, 1'b0, 1'b1, CT_FREE), 1'b0, '0);
        enqueue(pack_event(OP_KEY,        KC_SHIFT,     1'b0, 1'b0, 1'b0, CT_SPARE), 1'b0, '0);
        enqueue(pack_event(OP_KEY,        KC_SHIFT,     1'b0, 1'b0, 1'b0, CT_FREE), 1'b0, '0);
        enqueue(pack_event(OP_KEY,        KC_FN,        1'b1, 1'b0, 1'b0, CT_FREE), 1'b0, '0);
        enqueue(pack_event(OP_KEY,        KC_SHIFT,     1'b1, 1'b0, 1'b0, CT_FREE), 1'b0, '0);
        enqueue(pack_event(OP_KEY,        KC_CHAR,      1'b1, 1'b0, 1'b0, CT_FREE), 1'b0, '0);
        enqueue(pack_event(OP_KEY,        KC_SHIFT,     1'b0, 1'b0, 1'b0, CT_FREE), 1'b0, '0);
        enqueue(pack_event(OP_KEY,        KC_SYM,       1'b1, 1'b0, 1'b0, CT_FREE), 1'b0, '0);
        enqueue(pack_event(OP_KEY,        KC_CHAR,      1'b1, 1'b0, 1'b0, CT_FREE), 1'b0, '0);
        enqueue(pack_event(OP_KEY,        KC_MOD,       1'b1, 1'b0, 1'b0, CT_FREE), 1'b0, '0);
        enqueue(pack_event(OP_KEY,        KC_SYM,       1'b0, 1'b0, 1'b0, CT_FREE), 1'b0, '0);
        enqueue(pack_event(OP_KEY,        KC_SYM,       1'b1, 1'b0, 1'b0, CT_FREE), 1'b0, '0);
        enqueue(pack_event(OP_KEY,        KC_SYM,       1'b0, 1'b0, 1'b0, CT_FREE), 1'b0, '0);
        enqueue(pack_event(OP_KEY,        KC_OTHER_TOP, 1'b1, 1'b1, 1'b0, CT_FREE), 1'b0, '0);
        enqueue(pack_event(OP_AUTO_CAPS,  KC_SHIFT,     1'b0, 1'b0, 1'b1, CT_FREE), 1'b0, '0);
        enqueue(pack_event(OP_KEY,        KC_SHIFT,     1'b0, 1'b0, 1'b0, CT_FREE), 1'b0, '0);
        enqueue(pack_event(OP_IND_CLICK,  KC_SHIFT,     1'b0, 1'b0, 1'b0, CT_FREE), 1'b0, '0);
        enqueue(pack_event(OP_CONTENT,    KC_SHIFT,     1'b0, 1'b0, 1'b0, CT_NUMBER), 1'b0, '0);
        enqueue(pack_event(OP_KEY,        KC_FN,        1'b1, 1'b0, 1'b0, CT_FREE), 1'b0, '0);
        enqueue(pack_event(OP_CONTENT,    KC_SHIFT,     1'b0, 1'b0, 1'b0, CT_SPARE), 1'b0, '0);
        enqueue(pack_event(OP_CONTENT,    KC_SHIFT,     1'b0, 1'b0, 1'b0, CT_PHONE), 1'b0, '0);
        enqueue(pack_event(OP_SOFT_RESET, KC_SHIFT,     1'b0, 1'b0, 1'b0, CT_FREE), 1'b0, '0);
        enqueue(pack_event(OP_SPARE_TOP,  KC_OTHER_TOP, 1'b1, 1'b1, 1'b1, CT_SPARE),
                1'b1, want_quiet_phone);
        enqueue(pack_event(OP_CONTENT,    KC_SHIFT,     1'b0, 1'b0, 1'b0, CT_FREE), 1'b0, '0);
        n_directed = event_feed.size();

        while (event_feed.size() < n_directed + 600)
            add_gesture();

        // Hold reset, then release it for good
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sent = 0;
        burst_left = $urandom_range(1, 12);
        while (event_feed.size() != 0) begin
            ev    = event_feed.pop_front();
            typed = feed_typed.pop_front();
            took  = feed_want.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= {ev.content_type_value, ev.caps_value, ev.force_processing,
                         ev.key_pressed, ev.key_class};
            s_tuser  <= ev.op;
            do @(posedge clk); while (!s_tready);

            // Transfer taken: advance the mirror even where the row is hand-typed
            if (typed)
                void'(track_event(ev));
            else
                took = track_event(ev);
            owed_results.push_back(took);
            sent++;
            burst_left--;

            if (sent == n_directed || sent == n_directed + 300) begin
                // Drain completely before going on
                s_tvalid <= 1'b0;
                do @(posedge clk); while (owed_results.size() != 0);
            end
            else if (burst_left <= 0) begin
                // Close the burst; now and then a long stretch without gaps follows
                gap = $urandom_range(0, 6);
                burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 12);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        s_tvalid <= 1'b0;

        // Wait for the last results, then watch on for anything stray
        do @(posedge clk); while (owed_results.size() != 0);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Give up long after the slowest correct run would have finished
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
